[rtl/sbsm_pkg.sv]
// ----------------------------------------------------------------------------
// sbsm_pkg
// shared types and codes for the serial bank switch mapper
// ----------------------------------------------------------------------------
package sbsm_pkg;

    // access kinds carried in tuser
    localparam logic [2:0] KIND_CPU_READ  = 3'd0;
    localparam logic [2:0] KIND_CPU_WRITE = 3'd1;
    localparam logic [2:0] KIND_PPU_READ  = 3'd2;
    localparam logic [2:0] KIND_PPU_WRITE = 3'd3;
    localparam logic [2:0] KIND_RESET     = 3'd4;

    // loader commit targets, from address bits 14:13
    localparam logic [1:0] TGT_CONTROL  = 2'd0;
    localparam logic [1:0] TGT_CHR_LOW  = 2'd1;
    localparam logic [1:0] TGT_CHR_HIGH = 2'd2;
    localparam logic [1:0] TGT_PRG      = 2'd3;

    // program modes, control bits 3:2
    localparam logic [1:0] PRG_MODE_32K_A    = 2'd0;
    localparam logic [1:0] PRG_MODE_32K_B    = 2'd1;
    localparam logic [1:0] PRG_MODE_FIX_LOW  = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_HIGH = 2'd3;

    // configuration register indexes
    localparam logic CFG_PRG_BANK_COUNT = 1'b0;
    localparam logic CFG_CHR_BANK_COUNT = 1'b1;

    localparam logic [4:0] CONTROL_RESET   = 5'h1C;
    localparam logic [4:0] PRG_COUNT_RESET = 5'd16;
    localparam logic [7:0] CHR_COUNT_RESET = 8'd16;

    // last program bank for the power-up bank count
    localparam logic [3:0] PRG_LAST_RESET  = 4'(PRG_COUNT_RESET - 5'd1);

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_item;

    typedef struct packed {
        logic [4:0] control;
        logic [4:0] shift_value;
        logic [2:0] shift_count;
        logic [4:0] chr_low_bank;
        logic [4:0] chr_high_bank;
        logic [3:0] chr_full_bank;
        logic [3:0] prg_low_bank;
        logic [3:0] prg_high_bank;
        logic [2:0] prg_full_bank;
    } t_bank_state;

endpackage

[rtl/serial_bank_switch_mapper.sv]
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper
// cartridge bank mapper with a five-bit serial register loader
// ----------------------------------------------------------------------------
// usage:
//   each input item is one bus access: tuser holds the kind (cpu read, cpu
//   write, ppu read, ppu write, mapper reset), tdata the address and the
//   write byte. each item yields exactly one output item: tuser is the hit
//   flag, tdata the offset into program or character memory (zero on miss).
//   cpu writes never hit; they feed the serial loader and bank registers.
// timing:
//   an accepted item sits in the input register, where it is
//   translated and updates the bank state, then moves to the output
//   register, where its result becomes valid; the output handshake thus
//   follows the input handshake by way of both registers.
//   one item per cycle sustained while m_axis_tready stays high; the single
//   combinational pass between the two registers sets that rate.
// stalls:
//   when m_axis_tready is low the output register holds; the input register
//   still takes one more item, then s_axis_tready drops until space frees.
// reset:
//   i_rst_n (synchronous, active low) empties both registers, sets both bank
//   counts to 16 and the mapper state to its power-up values.
// configuration:
//   i_cfg_we writes i_cfg_data to register i_cfg_idx (0 program bank count,
//   1 character bank count); the user must write only while no item is in flight, the block does not enforce it.
// ----------------------------------------------------------------------------
module serial_bank_switch_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // addr[15:0], data[23:16]
    input  logic [2:0]  s_axis_tuser,   // kind[2:0]
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // mem_offset[17:0], zero pad[23:18]
    output logic        m_axis_tuser,   // hit[0]
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    // configuration registers
    logic [4:0] r_prg_bank_count;
    logic [7:0] r_chr_bank_count;

    // input register
    logic            r_in_valid;
    sbsm_pkg::t_item r_in_item;

    // output register
    logic        r_out_valid;
    logic        r_out_hit;
    logic [17:0] r_out_mem_offset;

    logic                  w_advance;
    logic [3:0]            w_last_bank;
    sbsm_pkg::t_bank_state w_state;
    logic                  w_hit;
    logic [17:0]           w_mem_offset;

    // item moves from input to output register when output is free
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    // last program bank wraps modulo 16
    assign w_last_bank = r_prg_bank_count[3:0] - 4'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_bank_count <= sbsm_pkg::PRG_COUNT_RESET;
            r_chr_bank_count <= sbsm_pkg::CHR_COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sbsm_pkg::CFG_PRG_BANK_COUNT: r_prg_bank_count <= i_cfg_data[4:0];
                sbsm_pkg::CFG_CHR_BANK_COUNT: r_chr_bank_count <= i_cfg_data;
                default: r_chr_bank_count <= r_chr_bank_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.kind <= s_axis_tuser;
            r_in_item.addr <= s_axis_tdata[15:0];
            r_in_item.data <= s_axis_tdata[23:16];
        end
    end

    // state update happens together with the translation of the same item
    sbsm_loader u_loader (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_advance),
        .i_item      (r_in_item),
        .i_last_bank (w_last_bank),
        .o_state     (w_state)
    );

    sbsm_xlate u_xlate (
        .i_item       (r_in_item),
        .i_state      (w_state),
        .i_chr_ram    (r_chr_bank_count == 8'd0),
        .o_hit        (w_hit),
        .o_mem_offset (w_mem_offset)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_hit        <= w_hit;
            r_out_mem_offset <= w_mem_offset;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_hit;
    assign m_axis_tdata  = {6'd0, r_out_mem_offset};

endmodule

[rtl/sbsm_loader.sv]
// ----------------------------------------------------------------------------
// sbsm_loader
// serial loader and bank registers, updated once per processed item
// ----------------------------------------------------------------------------
module sbsm_loader (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  sbsm_pkg::t_item      i_item,
    input  logic [3:0]           i_last_bank,
    output sbsm_pkg::t_bank_state o_state
);

    sbsm_pkg::t_bank_state r_state;
    sbsm_pkg::t_bank_state n_state;
    sbsm_pkg::t_bank_state w_clear;
    sbsm_pkg::t_bank_state w_power_up;

    logic [4:0] w_shifted;
    logic [2:0] w_count_inc;

    always_comb begin
        w_clear               = '0;
        w_clear.control       = sbsm_pkg::CONTROL_RESET;
        w_clear.prg_high_bank = i_last_bank;
        // power-up values follow the reset bank count
        w_power_up               = '0;
        w_power_up.control       = sbsm_pkg::CONTROL_RESET;
        w_power_up.prg_high_bank = sbsm_pkg::PRG_LAST_RESET;
    end

    assign w_shifted   = {i_item.data[0], r_state.shift_value[4:1]};
    assign w_count_inc = r_state.shift_count + 3'd1;

    always_comb begin
        n_state = r_state;
        case (i_item.kind)
            sbsm_pkg::KIND_CPU_WRITE: begin
                if (i_item.addr[15]) begin
                    if (i_item.data[7]) begin
                        // loader clear forces the fix-high program mode
                        n_state.shift_value  = '0;
                        n_state.shift_count  = '0;
                        n_state.control[3:2] = sbsm_pkg::PRG_MODE_FIX_HIGH;
                    end else if (w_count_inc >= 3'd5) begin
                        n_state.shift_value = '0;
                        n_state.shift_count = '0;
                        case (i_item.addr[14:13])
                            sbsm_pkg::TGT_CONTROL: begin
                                n_state.control = w_shifted;
                            end
                            sbsm_pkg::TGT_CHR_LOW: begin
                                if (r_state.control[4]) begin
                                    n_state.chr_low_bank = w_shifted;
                                end else begin
                                    n_state.chr_full_bank = w_shifted[4:1];
                                end
                            end
                            sbsm_pkg::TGT_CHR_HIGH: begin
                                if (r_state.control[4]) begin
                                    n_state.chr_high_bank = w_shifted;
                                end
                            end
                            default: begin
                                case (r_state.control[3:2])
                                    sbsm_pkg::PRG_MODE_FIX_LOW: begin
                                        n_state.prg_low_bank  = '0;
                                        n_state.prg_high_bank = w_shifted[3:0];
                                    end
                                    sbsm_pkg::PRG_MODE_FIX_HIGH: begin
                                        n_state.prg_low_bank  = w_shifted[3:0];
                                        n_state.prg_high_bank = i_last_bank;
                                    end
                                    default: begin
                                        n_state.prg_full_bank = w_shifted[3:1];
                                    end
                                endcase
                            end
                        endcase
                    end else begin
                        n_state.shift_value = w_shifted;
                        n_state.shift_count = w_count_inc;
                    end
                end
            end
            sbsm_pkg::KIND_RESET: begin
                n_state = w_clear;
            end
            default: begin
                n_state = r_state;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= w_power_up;
        end else if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

[rtl/sbsm_xlate.sv]
// ----------------------------------------------------------------------------
// sbsm_xlate
// address translation of cpu and ppu accesses through the bank registers
// ----------------------------------------------------------------------------
module sbsm_xlate (
    input  sbsm_pkg::t_item       i_item,
    input  sbsm_pkg::t_bank_state i_state,
    input  logic                  i_chr_ram,
    output logic                  o_hit,
    output logic [17:0]           o_mem_offset
);

    logic [3:0] w_prg_bank;
    logic [4:0] w_chr_bank;

    assign w_prg_bank = i_item.addr[14] ? i_state.prg_high_bank : i_state.prg_low_bank;
    assign w_chr_bank = i_item.addr[12] ? i_state.chr_high_bank : i_state.chr_low_bank;

    always_comb begin
        o_hit        = 1'b0;
        o_mem_offset = '0;
        case (i_item.kind)
            sbsm_pkg::KIND_CPU_READ: begin
                if (i_item.addr[15]) begin
                    o_hit = 1'b1;
                    if (i_state.control[3]) begin
                        o_mem_offset = {w_prg_bank, i_item.addr[13:0]};
                    end else begin
                        o_mem_offset = {i_state.prg_full_bank, i_item.addr[14:0]};
                    end
                end
            end
            sbsm_pkg::KIND_PPU_READ: begin
                if (i_item.addr[15:13] == 3'd0) begin
                    o_hit = 1'b1;
                    if (i_chr_ram) begin
                        o_mem_offset = {5'd0, i_item.addr[12:0]};
                    end else if (i_state.control[4]) begin
                        o_mem_offset = {1'b0, w_chr_bank, i_item.addr[11:0]};
                    end else begin
                        o_mem_offset = {1'b0, i_state.chr_full_bank, i_item.addr[12:0]};
                    end
                end
            end
            sbsm_pkg::KIND_PPU_WRITE: begin
                if (i_item.addr[15:13] == 3'd0 && i_chr_ram) begin
                    o_hit        = 1'b1;
                    o_mem_offset = {5'd0, i_item.addr[12:0]};
                end
            end
            default: begin
                o_hit        = 1'b0;
                o_mem_offset = '0;
            end
        endcase
    end

endmodule
